// ===== rtl/core/pfk_pkg.sv =====
// Shared types, sizes and the CORDIC arctangent table for the planar arm
// forward kinematics block. No dependencies.
`timescale 1ns / 1ps

package pfk_pkg;

	localparam int MAX_LINKS     = 16;
	localparam int CORDIC_STAGES = 16;

	localparam int CNT_W   = $clog2(MAX_LINKS + 1);
	localparam int STG_W   = $clog2(CORDIC_STAGES);
	localparam int ATAN_W  = 5;
	localparam int ROT_W   = 32;   // Q2.30 vector, 2^32 per turn angle
	localparam int PROD_W  = 48;
	localparam int TERM_W  = 34;
	localparam int SUM_W   = 40;
	localparam int POS_W   = 21;
	localparam int ANG_W   = 16;
	localparam int LEN_W   = 16;

	localparam logic signed [ROT_W-1:0] INV_GAIN = 32'sd652032874;

	localparam logic [ROT_W-1:0] ATAN_TAB [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// per-link bookkeeping that rides along the rotator chain
	typedef struct packed {
		logic             last;
		logic             flip;
		logic [LEN_W-1:0] len;
		logic [ANG_W-1:0] ang;
	} pfk_tag_t;

	typedef struct packed {
		pfk_tag_t                tag;
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ROT_W-1:0] z;
	} pfk_rot_t;

	// finished arm: unrounded sums and final heading
	typedef struct packed {
		logic [ANG_W-1:0]        ang;
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
	} pfk_fin_t;

	function automatic logic [ROT_W-1:0] atan_q32(input logic [ATAN_W-1:0] i);
		return ATAN_TAB[i];
	endfunction

endpackage

// ===== rtl/core/planar_arm_forward_kinematics.sv =====
// Top level of the planar arm forward kinematics block: heading front end,
// CORDIC cell chain, accumulator and output register. Depends on pfk_pkg,
// pfk_cordic_cell and pfk_accum.
`timescale 1ns / 1ps

// One link word enters per cycle. The word that ends an arm passes the input
// register, the CORDIC cell registers, the multiply and rounding registers,
// the accumulator and the output register, and its result word follows. Only
// the heading, the link count and the x/y accumulators feed back, so links
// stream at full rate. An arm ends on tlast or on its MAX_LINKS-th link,
// whichever comes first; end_angle is the wrapped sum of the joint angles.
// The input only stalls while a finished result sits at the end of the
// pipeline and the output word has not been taken.

module planar_arm_forward_kinematics import pfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] link_length, [31:16] joint_angle
	input  logic        s_axis_tlast,   // last_link
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // [20:0] pos_x, [41:21] pos_y, [57:42] end_angle
);

	logic             adv, acc, last_eff, flip;
	logic [ANG_W-1:0] ang_new, h_red;
	logic [ANG_W-1:0] heading_q;
	logic [CNT_W-1:0] cnt_q;

	logic             vld_s1;
	pfk_tag_t         tag_s1;
	logic [ANG_W-1:0] h_s1;

	logic             cvld [CORDIC_STAGES+1];
	pfk_rot_t         crot [CORDIC_STAGES+1];

	logic             fin_vld;
	pfk_fin_t         fin;

	logic             out_vld_q;
	logic [63:0]      out_data_q;

	function automatic logic [POS_W-1:0] finish_pos(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W:0] r;
		r = ($signed({s[SUM_W-1], s}) + (SUM_W+1)'(32768)) >>> 16;
		if (r > (SUM_W+1)'(1048575))
			return POS_W'(1048575);
		else if (r < -(SUM_W+1)'(1048576))
			return POS_W'(1048576);
		else
			return r[POS_W-1:0];
	endfunction

	// freeze only when a finished result cannot move into the output register
	assign adv           = !(fin_vld && out_vld_q && !m_axis_tready);
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && adv;

	always_comb begin
		ang_new  = heading_q + s_axis_tdata[31:16];
		last_eff = s_axis_tlast || (cnt_q == CNT_W'(MAX_LINKS - 1));
		flip     = ($signed(ang_new) > 16'sd16384) || ($signed(ang_new) < -16'sd16384);
		// half-turn rotation: flip the top bit, negate cos and sin later
		h_red    = flip ? {~ang_new[ANG_W-1], ang_new[ANG_W-2:0]} : ang_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (acc) begin
				heading_q <= last_eff ? '0 : ang_new;
				cnt_q     <= last_eff ? '0 : cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tag_s1.last <= last_eff;
			tag_s1.flip <= flip;
			tag_s1.len  <= s_axis_tdata[15:0];
			tag_s1.ang  <= ang_new;
			h_s1        <= h_red;
		end
	end

	always_comb begin
		cvld[0]     = vld_s1;
		crot[0].tag = tag_s1;
		crot[0].x   = INV_GAIN;
		crot[0].y   = '0;
		crot[0].z   = $signed({h_s1, 16'h0000});
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		pfk_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.stage  (STG_W'(i)),
			.d_vld  (cvld[i]),
			.d      (crot[i]),
			.q_vld  (cvld[i+1]),
			.q      (crot[i+1])
		);
	end

	pfk_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.d_vld   (cvld[CORDIC_STAGES]),
		.d       (crot[CORDIC_STAGES]),
		.fin_vld (fin_vld),
		.fin     (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && fin_vld) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_vld) begin
			out_data_q <= {6'b0, fin.ang, finish_pos(fin.sy), finish_pos(fin.sx)};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/pfk_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// Depends on pfk_pkg.
`timescale 1ns / 1ps

module pfk_cordic_cell import pfk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [STG_W-1:0] stage,
	input  logic             d_vld,
	input  pfk_rot_t         d,
	output logic             q_vld,
	output pfk_rot_t         q
);

	logic signed [ROT_W-1:0] dx, dy, at;
	pfk_rot_t                nxt;
	logic                    vld_s1;
	pfk_rot_t                rot_s1;

	always_comb begin
		dx  = d.y >>> stage;
		dy  = d.x >>> stage;
		at  = $signed(atan_q32(ATAN_W'(stage)));
		nxt = d;
		if (!d.z[ROT_W-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - at;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= nxt;
		end
	end

	assign q_vld = vld_s1;
	assign q     = rot_s1;

endmodule

// ===== rtl/core/pfk_accum.sv =====
// Link term multiply, rounding and x/y accumulation; emits the finished sums
// on the last link of an arm. Depends on pfk_pkg.
`timescale 1ns / 1ps

module pfk_accum import pfk_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     d_vld,
	input  pfk_rot_t d,
	output logic     fin_vld,
	output pfk_fin_t fin
);

	logic                     vld_s1, vld_s2, fin_vld_q;
	pfk_tag_t                 tag_s1, tag_s2;
	logic signed [PROD_W-1:0] px_s1, py_s1;
	logic signed [TERM_W-1:0] tx_s2, ty_s2;
	logic signed [SUM_W-1:0]  sum_x_q, sum_y_q;
	pfk_fin_t                 fin_q;

	logic signed [LEN_W:0]    len_s;
	logic signed [PROD_W-1:0] nx, ny, rx, ry;
	logic signed [SUM_W-1:0]  tot_x, tot_y;

	always_comb begin
		len_s = $signed({1'b0, d.tag.len});
		nx    = tag_s1.flip ? -px_s1 : px_s1;
		ny    = tag_s1.flip ? -py_s1 : py_s1;
		rx    = (nx + PROD_W'(8192)) >>> 14;
		ry    = (ny + PROD_W'(8192)) >>> 14;
		tot_x = sum_x_q + SUM_W'(tx_s2);
		tot_y = sum_y_q + SUM_W'(ty_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			fin_vld_q <= 1'b0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
		end else if (en) begin
			vld_s1    <= d_vld;
			vld_s2    <= vld_s1;
			fin_vld_q <= vld_s2 && tag_s2.last;
			if (vld_s2) begin
				if (tag_s2.last) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
				end else begin
					sum_x_q <= tot_x;
					sum_y_q <= tot_y;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1    <= d.tag;
			px_s1     <= PROD_W'(len_s) * PROD_W'($signed(d.x));
			py_s1     <= PROD_W'(len_s) * PROD_W'($signed(d.y));
			tag_s2    <= tag_s1;
			tx_s2     <= TERM_W'(rx);
			ty_s2     <= TERM_W'(ry);
			fin_q.ang <= tag_s2.ang;
			fin_q.sx  <= tot_x;
			fin_q.sy  <= tot_y;
		end
	end

	assign fin_vld = fin_vld_q;
	assign fin     = fin_q;

endmodule

// ===== bench/planar_arm_forward_kinematics_tb.sv =====
// Self-checking bench for planar_arm_forward_kinematics: streams arm links, predicts
// the end pose with its own fixed-point CORDIC and compares every output word.
// Depends on pfk_pkg and the block's RTL.
`timescale 1ns / 1ps

module planar_arm_forward_kinematics_tb;
	import pfk_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [ANG_W-1:0]        ang;
	} arm_pose_t;

	// arctangent per stage, 2^32 per turn
	localparam longint STAGE_ATAN [24] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
		'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
		'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
		'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
		'h0000028C, 'h00000146, 'h000000A3, 'h00000051
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;

	// predicted arm state
	logic [ANG_W-1:0] arm_heading;
	longint           arm_sum_x;
	longint           arm_sum_y;
	int               arm_links;

	arm_pose_t pose_q[$];
	int        err_count;
	int        tx_idle_pct;
	int        rx_idle_pct;
	int        rx_hold;
	int        quiet_cycles;

	planar_arm_forward_kinematics u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		err_count++;
	endtask

	// cos/sin of a binary angle in Q2.30
	function automatic void unit_vector(input logic [ANG_W-1:0] ang, output longint c,
		output longint s);
		longint h, x, y, z, dx, dy;
		bit flip;
		h = longint'($signed(ang));
		flip = 1'b0;
		// fold into [-1/4, +1/4] turn; half-turn negates both outputs
		if (h > 16384) begin
			h -= 32768;
			flip = 1'b1;
		end else if (h < -16384) begin
			h += 32768;
			flip = 1'b1;
		end
		x = 64'sd652032874;
		y = 0;
		z = h * 65536;
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= STAGE_ATAN[i];
			end else begin
				x += dx;
				y -= dy;
				z += STAGE_ATAN[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic signed [POS_W-1:0] round_position(input longint sum);
		longint v;
		v = (sum + 32768) >>> 16;
		if (v > 1048575)
			v = 1048575;
		if (v < -1048576)
			v = -1048576;
		return v[POS_W-1:0];
	endfunction

	function automatic void take_link(input logic [LEN_W-1:0] len, input logic [ANG_W-1:0] ang,
		input bit last);
		longint c, s, l;
		arm_pose_t pose;
		l = longint'(len);
		arm_heading = arm_heading + ang;
		unit_vector(arm_heading, c, s);
		arm_sum_x += (l * c + 8192) >>> 14;
		arm_sum_y += (l * s + 8192) >>> 14;
		arm_links++;
		// the MAX_LINKS-th link closes the arm even without tlast
		if (last || arm_links >= MAX_LINKS) begin
			pose.x = round_position(arm_sum_x);
			pose.y = round_position(arm_sum_y);
			pose.ang = arm_heading;
			pose_q.push_back(pose);
			arm_heading = '0;
			arm_sum_x = 0;
			arm_sum_y = 0;
			arm_links = 0;
		end
	endfunction

	task automatic send_link(input logic [LEN_W-1:0] len, input logic [ANG_W-1:0] ang,
		input bit last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ang, len};
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		take_link(len, ang, last);
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return LEN_W'($urandom);
		endcase
	endfunction

	function automatic logic [ANG_W-1:0] pick_angle();
		logic [ANG_W-1:0] edges [7] = '{16'h0000, 16'h4000, 16'hC000, 16'h4001, 16'hBFFF,
			16'h8000, 16'h7FFF};
		if ($urandom_range(0, 7) == 0)
			return edges[$urandom_range(0, 6)];
		return ANG_W'($urandom);
	endfunction

	// one arm; tlast on its final link, or scattered at random when noisy
	task automatic send_arm(input int links, input bit noisy);
		bit last;
		for (int i = 0; i < links; i++) begin
			last = noisy ? ($urandom_range(0, 3) == 0) : (i == links - 1);
			send_link(pick_length(), pick_angle(), last);
		end
	endtask

	task automatic wait_drained();
		while (pose_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_link(16'd0, 16'h0000, 1'b1);
		send_link(16'hFFFF, 16'h0000, 1'b1);
		send_link(16'hFFFF, 16'h4000, 1'b1);
		send_link(16'hFFFF, 16'h8000, 1'b1);
		// fold boundary: -1/4 turn then one step past it
		send_link(16'hFFFF, 16'hC000, 1'b0);
		send_link(16'hFFFF, 16'hFFFF, 1'b1);
		// heading wraps past a half turn
		send_link(16'd100, 16'h7FFF, 1'b0);
		send_link(16'd100, 16'h7FFF, 1'b0);
		send_link(16'd0, 16'h4001, 1'b1);
		// full-length straight arm closed by the link limit
		for (int i = 0; i < MAX_LINKS; i++)
			send_link(16'hFFFF, 16'h0000, 1'b0);
	endtask

	task automatic test_random(input int n_items);
		int sent, links;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0)
				links = $urandom_range(MAX_LINKS - 1, MAX_LINKS + 6);
			else
				links = $urandom_range(1, 6);
			send_arm(links, $urandom_range(0, 9) == 0);
			sent += links;
		end
	endtask

	// output held off while the sender keeps pushing: pipeline fills, input stalls
	task automatic test_receiver_holdoff();
		rx_hold = HOLDOFF_CYCLES;
		for (int i = 0; i < 30; i++)
			send_arm($urandom_range(1, 6), 1'b0);
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 10; i++) begin
			send_arm($urandom_range(1, 8), 1'b0);
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end
	endtask

	// result side: check accepted words, then pick next tready
	always @(posedge clk) begin
		arm_pose_t exp_pose;
		logic signed [POS_W-1:0] got_x, got_y;
		logic [ANG_W-1:0] got_ang;
		got_x   = m_axis_tdata[20:0];
		got_y   = m_axis_tdata[41:21];
		got_ang = m_axis_tdata[57:42];
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pose_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word x=%0d y=%0d ang=%0d",
					got_x, got_y, got_ang));
			end else begin
				exp_pose = pose_q.pop_front();
				if (got_x !== exp_pose.x)
					report_mismatch($sformatf("pos_x got %0d exp %0d", got_x, exp_pose.x));
				if (got_y !== exp_pose.y)
					report_mismatch($sformatf("pos_y got %0d exp %0d", got_y, exp_pose.y));
				if (got_ang !== exp_pose.ang)
					report_mismatch($sformatf("end_angle got %0d exp %0d",
						$signed(got_ang), $signed(exp_pose.ang)));
			end
		end
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		err_count     = 0;
		rx_hold       = 0;
		quiet_cycles  = 0;
		tx_idle_pct   = 7;
		rx_idle_pct   = 74;
		arm_heading   = '0;
		arm_sum_x     = 0;
		arm_sum_y     = 0;
		arm_links     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(580);
		test_receiver_holdoff();

		tx_idle_pct = 74;
		rx_idle_pct = 7;
		test_random(580);
		test_drain_pause();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(580);

		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pfk_pkg.sv
rtl/core/pfk_cordic_cell.sv
rtl/core/pfk_accum.sv
rtl/core/planar_arm_forward_kinematics.sv
bench/planar_arm_forward_kinematics_tb.sv
